### src/tcs_pkg.sv
// Shared types and constants of the three-channel temperature smoother.
// Used by tcs_die_conv, tcs_lane and three_channel_temp_smoother.
package tcs_pkg;

  localparam int unsigned TCS_FRAC_BITS    = 16;
  localparam int unsigned TCS_INT_BITS     = 15;
  localparam int unsigned TCS_OUT_SHIFT    = 7;
  localparam int unsigned TCS_WEIGHT_BITS  = 16;
  localparam int unsigned TCS_WORD_W       = 16;
  localparam int unsigned TCS_RAW_BITS     = 26;
  localparam int unsigned TCS_DIE_GAIN     = 537;
  localparam longint      TCS_DIE_OFFSET   = 900000;
  localparam int unsigned TCS_DIE_DIV      = 2950;
  localparam int unsigned TCS_REM_W        = 12;
  localparam int unsigned TCS_DIV_STEP     = 6;
  localparam int unsigned TCS_CHANNELS     = 3;
  localparam int unsigned TCS_DIE_TEMP_W   = 22;
  localparam int unsigned TCS_EXT_TEMP_W   = 16;
  localparam logic [16:0] TCS_WEIGHT_RESET = 17'd1311;

  localparam logic [1:0] CMD_FRAME   = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SMOOTH,
    ST_HOLD
  } tcs_state_e;

  typedef struct packed {
    logic start;
    logic clear;
  } lane_ctrl_t;

endpackage

### src/tcs_die_conv.sv
// Die word to fixed-point degrees: (w*537 - 900000) * 2^F / 2950, floored.
// Long division by the constant, several quotient bits per cycle. Uses tcs_pkg.
module tcs_die_conv
  import tcs_pkg::*;
#(
  parameter int unsigned FRAC_BITS = TCS_FRAC_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic [TCS_WORD_W-1:0]                   word_i,
  output logic                                    done_o,
  output logic signed [FRAC_BITS+TCS_INT_BITS-1:0] sample_o
);

  localparam int unsigned AW    = FRAC_BITS + TCS_INT_BITS;
  localparam int unsigned WD    = TCS_RAW_BITS + FRAC_BITS;
  localparam int unsigned NSTEP = (WD + TCS_DIV_STEP - 1) / TCS_DIV_STEP;
  localparam int unsigned NW    = NSTEP * TCS_DIV_STEP;
  localparam int unsigned CW    = $clog2(NSTEP);
  localparam longint      CBIAS = TCS_DIE_OFFSET * (longint'(1) << FRAC_BITS);
  localparam longint      Q0    = (CBIAS + TCS_DIE_DIV - 1) / TCS_DIE_DIV;
  localparam longint      OFFS  = Q0 * TCS_DIE_DIV - CBIAS;
  localparam logic [NW-1:0]          Q0_V  = NW'(Q0);
  localparam logic [NW-1:0]          OFF_V = NW'(OFFS);
  localparam logic [TCS_REM_W:0]     DIV_V = (TCS_REM_W + 1)'(TCS_DIE_DIV);
  localparam logic [CW-1:0]          LAST  = CW'(NSTEP - 1);

  logic [NW-1:0]           num_q, num_d, quo_q, quo_d;
  logic [TCS_REM_W-1:0]    rem_q, rem_d;
  logic [CW-1:0]           cnt_q;
  logic                    busy_q, last_q, done_q;
  logic signed [AW-1:0]    sample_q;
  logic [TCS_RAW_BITS-1:0] raw;

  assign raw = {(TCS_RAW_BITS-TCS_WORD_W)'(0), word_i} * TCS_RAW_BITS'(TCS_DIE_GAIN);

  always_comb begin
    logic [TCS_REM_W:0] trial;
    rem_d = rem_q;
    num_d = num_q;
    quo_d = quo_q;
    for (int k = 0; k < TCS_DIV_STEP; k++) begin
      trial = {rem_d, num_d[NW-1]};
      num_d = num_d << 1;
      if (trial >= DIV_V) begin
        rem_d = TCS_REM_W'(trial - DIV_V);
        quo_d = {quo_d[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[TCS_REM_W-1:0];
        quo_d = {quo_d[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      last_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= last_q;
      last_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= rem_d;
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          last_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= (NW'(raw) << FRAC_BITS) + OFF_V;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      quo_q <= quo_d;
    end
    if (last_q) begin
      sample_q <= AW'(quo_q - Q0_V);
    end
  end

  assign done_o   = done_q;
  assign sample_o = sample_q;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q < DIV_V[TCS_REM_W-1:0])
    else $error("division remainder out of range");
  a_one_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({busy_q, last_q, done_q}))
    else $error("converter phases overlap");
`endif

endmodule

### src/tcs_lane.sv
// One smoothing lane: exponential average of one channel, load on first sample
// or at a weight of 1.0 or more. Split multiply over registered partial products. Uses tcs_pkg.
module tcs_lane
  import tcs_pkg::*;
#(
  parameter int unsigned FRAC_BITS = TCS_FRAC_BITS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  lane_ctrl_t                               ctrl_i,
  input  logic signed [FRAC_BITS+TCS_INT_BITS-1:0] sample_i,
  input  logic [TCS_WEIGHT_BITS:0]                 weight_i,
  output logic                                     done_o,
  output logic [TCS_DIE_TEMP_W-1:0]                temp_o
);

  localparam int unsigned AW = FRAC_BITS + TCS_INT_BITS;
  localparam int unsigned DW = AW + 1;
  localparam int unsigned H  = DW / 2;
  localparam int unsigned PH = DW - H + TCS_WEIGHT_BITS + 1;
  localparam int unsigned PL = H + TCS_WEIGHT_BITS;
  localparam int unsigned SW = DW + TCS_WEIGHT_BITS + 1;
  localparam int unsigned SH = FRAC_BITS - TCS_OUT_SHIFT;
  localparam logic [AW-1:0] BIAS = AW'((longint'(1) << SH) - 1);

  logic signed [AW-1:0] avg_q, rnd;
  logic                 primed_q;
  logic signed [DW-1:0] diff_q;
  logic signed [PH-1:0] phi_q;
  logic [PL-1:0]        plo_q;
  logic signed [SW-1:0] sum_q, sum_d, shr;
  logic                 v1_q, v2_q, v3_q, done_q;

  assign sum_d = ($signed(SW'(phi_q)) <<< H) + $signed({(SW-PL)'(0), plo_q});
  assign shr   = sum_q >>> TCS_WEIGHT_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      avg_q    <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      v1_q   <= 1'b0;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q;
      if (ctrl_i.clear) begin
        primed_q <= 1'b0;
      end
      if (ctrl_i.start) begin
        if (!primed_q || weight_i[TCS_WEIGHT_BITS]) begin
          avg_q    <= sample_i;
          primed_q <= 1'b1;
          done_q   <= 1'b1;
        end else begin
          v1_q <= 1'b1;
        end
      end
      if (v3_q) begin
        avg_q <= avg_q + AW'(shr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      diff_q <= DW'(sample_i) - DW'(avg_q);
    end
    if (v1_q) begin
      plo_q <= diff_q[H-1:0] * weight_i[TCS_WEIGHT_BITS-1:0];
      phi_q <= $signed(diff_q[DW-1:H]) * $signed({1'b0, weight_i[TCS_WEIGHT_BITS-1:0]});
    end
    if (v2_q) begin
      sum_q <= sum_d;
    end
  end

  assign rnd    = avg_q + (avg_q[AW-1] ? $signed(BIAS) : $signed(AW'(0)));
  assign temp_o = TCS_DIE_TEMP_W'(rnd >>> SH);
  assign done_o = done_q;

`ifndef SYNTHESIS
  a_done_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> primed_q)
    else $error("lane finished without a loaded average");
  a_one_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({v1_q, v2_q, v3_q, done_q}))
    else $error("lane stages overlap");
`endif

endmodule

### src/three_channel_temp_smoother.sv
// Top level of the three-channel temperature smoother.
// Instantiates tcs_die_conv and three tcs_lane copies; uses tcs_pkg.
//
// Usage:
//   Input words on s_axis: tuser carries the command (frame, failed read,
//   restart), tdata the die word and two external sensor words.
//   Each accepted word yields exactly one result word on m_axis: tuser is
//   the ok flag, tdata the three smoothed temperatures in 1/128 degree.
//   A frame is converted by the radix-64 divider of the die conversion,
//   then smoothed in the lanes' product, sum and average registers.
//   The first frame after reset or restart, and any frame at a weight of 1.0
//   or more, loads the averages directly and skips those lane registers.
//   A failed read or restart skips the divider and the lanes.
//   One word is worked on at a time; s_axis_tready_o is high while idle, so
//   a new word is taken only once the last result has gone to the output register.
//   The result sits in an output register; a new word is accepted while it
//   waits, and a finished result waits in the lanes until that register frees.
//   Reset clears the averages and primed flags and sets the weight to 1311.
//   cfg_we_i writes the smoothing weight (Q16); write only while idle.
module three_channel_temp_smoother
  import tcs_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = TCS_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // die_word [15:0], first_sensor_word [31:16], second_sensor_word [47:32]
  input  logic [47:0] s_axis_tdata_i,
  // cmd [1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // die_temp [21:0], first_sensor_temp [37:22], second_sensor_temp [53:38]
  output logic [55:0] m_axis_tdata_o,
  // ok [0]
  output logic [0:0]  m_axis_tuser_o
);

  localparam int unsigned AW = FRACTION_BITS + TCS_INT_BITS;
  localparam int unsigned XS = FRACTION_BITS - TCS_OUT_SHIFT;

  tcs_state_e                state_q, state_d;
  logic [TCS_WEIGHT_BITS:0]  weight_q;
  logic [TCS_WORD_W-1:0]     w1_q, w2_q;
  logic                      frame_q, frame_d;
  logic                      m_valid_q;
  logic [55:0]               m_data_q;
  logic                      m_ok_q;
  logic                      accept, load_out, conv_start, conv_done;
  lane_ctrl_t                lane_ctrl;
  logic signed [AW-1:0]      die_sample;
  logic signed [AW-1:0]      lane_sample [TCS_CHANNELS];
  logic [TCS_DIE_TEMP_W-1:0] lane_temp [TCS_CHANNELS];
  logic [TCS_CHANNELS-1:0]   lane_done;

  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign conv_start = accept && (s_axis_tuser_i == CMD_FRAME);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      weight_q  <= TCS_WEIGHT_RESET;
      frame_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      frame_q <= frame_d;
      if (cfg_we_i) begin
        weight_q <= cfg_wdata_i;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (conv_start) begin
      w1_q <= s_axis_tdata_i[31:16];
      w2_q <= s_axis_tdata_i[47:32];
    end
    if (load_out) begin
      m_ok_q   <= frame_q;
      m_data_q <= frame_q ? {2'b00, lane_temp[2][TCS_EXT_TEMP_W-1:0],
                             lane_temp[1][TCS_EXT_TEMP_W-1:0], lane_temp[0]} : '0;
    end
  end

  always_comb begin
    state_d         = state_q;
    frame_d         = frame_q;
    s_axis_tready_o = 1'b0;
    lane_ctrl.start = 1'b0;
    lane_ctrl.clear = 1'b0;
    load_out        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (accept) begin
          frame_d         = (s_axis_tuser_i == CMD_FRAME);
          lane_ctrl.clear = (s_axis_tuser_i == CMD_RESTART);
          state_d         = (s_axis_tuser_i == CMD_FRAME) ? ST_CONV : ST_HOLD;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          lane_ctrl.start = 1'b1;
          state_d         = ST_SMOOTH;
        end
      end
      ST_SMOOTH: begin
        if (&lane_done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!m_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  tcs_die_conv #(
    .FRAC_BITS(FRACTION_BITS)
  ) u_die_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (conv_start),
    .word_i   (s_axis_tdata_i[15:0]),
    .done_o   (conv_done),
    .sample_o (die_sample)
  );

  assign lane_sample[0] = die_sample;
  assign lane_sample[1] = $signed({{(AW-TCS_WORD_W){w1_q[TCS_WORD_W-1]}}, w1_q}) <<< XS;
  assign lane_sample[2] = $signed({{(AW-TCS_WORD_W){w2_q[TCS_WORD_W-1]}}, w2_q}) <<< XS;

  for (genvar g = 0; g < TCS_CHANNELS; g++) begin : g_lane
    tcs_lane #(
      .FRAC_BITS(FRACTION_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .sample_i (lane_sample[g]),
      .weight_i (weight_q),
      .done_o   (lane_done[g]),
      .temp_o   (lane_temp[g])
    );
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_ok_q;

`ifndef SYNTHESIS
  a_lanes_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|lane_done) |-> (&lane_done))
    else $error("lanes finished out of step");
  a_conv_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done |-> (state_q == ST_CONV))
    else $error("die conversion finished outside its state");
`endif

endmodule
